/* hdl/world_to_screen_projector_defines.svh */
// Assertion macros for the world to screen projector checker.
`ifndef WORLD_TO_SCREEN_PROJECTOR_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTOR_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define WSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert that a condition implies a consequence in the following cycle.
`define WSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/wsp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and codes of the world to screen projector.
// ----------------------------------------------------------------------------
package wsp_pkg;

  typedef enum logic [1:0] {
    ACT_VIEW    = 2'd0,
    ACT_PROJ    = 2'd1,
    ACT_COMPOSE = 2'd2,
    ACT_PROJECT = 2'd3
  } action_t;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMP_RD,
    ST_CMP_MAC,
    ST_CMP_WR,
    ST_PRJ_RD,
    ST_PRJ_MAC,
    ST_PRJ_SAT,
    ST_DIV,
    ST_SCALE,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

/* hdl/wsp_divider.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_divider
// Radix-2 restoring signed divider, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module wsp_divider #(
  parameter int NUM_W = 56,
  parameter int DEN_W = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic signed [DEN_W-1:0] den,
  output logic                         done,
  output logic signed [NUM_W-1:0]      quo
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DEN_W:0]   rem_r, rem_nxt;
  logic [DEN_W-1:0] d_r;
  logic             neg_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   shifted;

  always_comb begin
    shifted = {rem_r[DEN_W-1:0], q_r[NUM_W-1]};
    trial   = shifted - {1'b0, d_r};
    q_nxt   = {q_r[NUM_W-2:0], ~trial[DEN_W]};
    rem_nxt = trial[DEN_W] ? shifted : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NUM_W);
        q_r    <= num[NUM_W-1] ? NUM_W'(-num) : num;
        d_r    <= den[DEN_W-1] ? DEN_W'(-den) : den;
        neg_r  <= num[NUM_W-1] ^ den[DEN_W-1];
        rem_r  <= '0;
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quo = neg_r ? NUM_W'(-q_r) : q_r;
endmodule
`default_nettype wire

/* hdl/world_to_screen_projector.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// world_to_screen_projector
// Fixed-point view/projection matrix store and point-to-screen mapper.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A compose item runs 64 multiply-adds on one
// multiplier fed from the matrix memories before the next item is taken. A
// project item runs 9 multiply-adds, then two bit-serial divisions (x/w,
// y/w) in turn. A point behind the viewer skips the divisions. A waiting
// result does not block new items; a point that finishes while the previous
// result is still stalled holds until that result leaves. Memories hold zero
// after reset through valid bits, no clearing pass is needed.
module world_to_screen_projector #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [3:0]  in_element_index,
  input  wire logic signed [31:0] in_element_value,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] out_screen_x,
  output logic signed [31:0] out_screen_y,
  output logic             out_in_front,
  output logic             out_on_screen,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [13:0] cfg_data
);
  import wsp_pkg::*;

  localparam int NUM_W = 32 + FRAC_BITS + 1;
  localparam logic signed [63:0] W_MIN = 64'((64'sd1 <<< FRAC_BITS) / 20);
  localparam logic signed [63:0] FX_ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] RLIM = 64'sd1 <<< 40;

  logic signed [31:0] view_mem [16];
  logic signed [31:0] proj_mem [16];
  logic signed [31:0] comb_mem [16];
  logic [15:0] view_vld_r, proj_vld_r, comb_vld_r;
  logic signed [31:0] a_rd_r, b_rd_r;
  logic a_ok_r, b_ok_r;
  logic [3:0] a_addr, b_addr;
  logic a_src_comb;

  state_t st_r, st_nxt;
  logic [13:0] w_r, h_r;
  logic [1:0] i_r, j_r, k_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic signed [63:0] acc_r, prod_r;
  logic signed [31:0] cx_r, cy_r, cw_r;
  logic [1:0] col_r;
  logic div_sel_r;
  logic signed [63:0] rx_r, ry_r;
  logic signed [31:0] sx_r, sy_r;
  logic front_r;

  logic signed [31:0] a_val, b_val, mul_b;
  logic signed [63:0] sum, sat_v;
  logic div_start, div_done;
  logic signed [NUM_W-1:0] div_num, div_q;
  logic signed [31:0] div_den;
  logic signed [63:0] rclamp;
  logic out_load;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // operand addresses: compose uses view[i][k] x proj[k][j], project uses comb[k][col]
  always_comb begin
    a_src_comb = (st_r == ST_PRJ_RD);
    a_addr = a_src_comb ? {k_r, col_r} : {i_r, k_r};
    b_addr = {k_r, j_r};
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall && in_action == ACT_VIEW) view_mem[in_element_index] <= in_element_value;
    if (in_valid && !in_stall && in_action == ACT_PROJ) proj_mem[in_element_index] <= in_element_value;
    if (st_r == ST_CMP_WR) comb_mem[{i_r, j_r}] <= sat_v[31:0];
    a_rd_r <= a_src_comb ? comb_mem[a_addr] : view_mem[a_addr];
    a_ok_r <= a_src_comb ? comb_vld_r[a_addr] : view_vld_r[a_addr];
    b_rd_r <= proj_mem[b_addr];
    b_ok_r <= proj_vld_r[b_addr];
  end

  assign a_val = a_ok_r ? a_rd_r : 32'sd0;
  assign b_val = b_ok_r ? b_rd_r : 32'sd0;
  // project: the translation row (k==3) adds directly
  always_comb begin
    unique case (k_r)
      2'd0: mul_b = px_r;
      2'd1: mul_b = py_r;
      default: mul_b = pz_r;
    endcase
  end

  assign sum = acc_r + prod_r;
  assign sat_v = 64'(sat32(sum));
  // first division starts from the last column state, the second from the divide state
  assign div_num = ((st_r == ST_DIV) ? NUM_W'(cy_r) : NUM_W'(cx_r)) <<< FRAC_BITS;
  assign div_den = (st_r == ST_PRJ_SAT) ? sat_v[31:0] : cw_r;
  assign rclamp = (64'(div_q) > RLIM) ? RLIM : ((64'(div_q) < -RLIM) ? -RLIM : 64'(div_q));

  wsp_divider #(.NUM_W(NUM_W), .DEN_W(32)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  assign in_stall = (st_r != ST_IDLE);
  // hold a finished point while the previous result still waits
  assign out_load = (st_r == ST_OUT) && !(out_valid && out_stall);

  always_comb begin
    st_nxt = st_r;
    div_start = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          if (in_action == ACT_COMPOSE) st_nxt = ST_CMP_RD;
          else if (in_action == ACT_PROJECT) st_nxt = ST_PRJ_RD;
        end
      end
      ST_CMP_RD: st_nxt = ST_CMP_MAC;
      ST_CMP_MAC: st_nxt = (k_r == 2'd3) ? ST_CMP_WR : ST_CMP_RD;
      ST_CMP_WR: st_nxt = (i_r == 2'd3 && j_r == 2'd3) ? ST_IDLE : ST_CMP_RD;
      ST_PRJ_RD: st_nxt = ST_PRJ_MAC;
      ST_PRJ_MAC: st_nxt = (k_r == 2'd3) ? ST_PRJ_SAT : ST_PRJ_RD;
      ST_PRJ_SAT: begin
        if (col_r == 2'd3) begin
          if (sat_v > W_MIN) begin
            st_nxt = ST_DIV;
            div_start = 1'b1;
          end else begin
            st_nxt = ST_OUT;
          end
        end else begin
          st_nxt = ST_PRJ_RD;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_sel_r) st_nxt = ST_SCALE;
          else div_start = 1'b1;
        end
      end
      ST_SCALE: st_nxt = ST_OUT;
      ST_OUT: st_nxt = out_load ? ST_IDLE : ST_OUT;
      default: st_nxt = ST_IDLE;
    endcase
  end

  logic signed [63:0] ext_x, ext_y;
  assign ext_x = 64'($signed({1'b0, w_r})) * (FX_ONE + rx_r);
  assign ext_y = 64'($signed({1'b0, h_r})) * (FX_ONE - ry_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      out_valid <= 1'b0;
      view_vld_r <= '0;
      proj_vld_r <= '0;
      comb_vld_r <= '0;
      w_r <= 14'd1920;
      h_r <= 14'd1080;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_WIDTH) w_r <= cfg_data;
        else h_r <= cfg_data;
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (in_valid && !in_stall && in_action == ACT_VIEW) view_vld_r[in_element_index] <= 1'b1;
      if (in_valid && !in_stall && in_action == ACT_PROJ) proj_vld_r[in_element_index] <= 1'b1;
      if (st_r == ST_CMP_WR) comb_vld_r[{i_r, j_r}] <= 1'b1;
      if (out_load) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        i_r <= '0; j_r <= '0; k_r <= '0; col_r <= '0; acc_r <= '0;
        px_r <= in_pos_x; py_r <= in_pos_y; pz_r <= in_pos_z;
        div_sel_r <= 1'b0;
      end
      ST_CMP_RD: ;
      ST_CMP_MAC: begin
        prod_r <= (64'(a_val) * 64'(b_val)) >>> FRAC_BITS;
        if (k_r != 2'd0) acc_r <= sum;
        k_r <= k_r + 1'b1;
      end
      ST_CMP_WR: begin
        acc_r <= '0; prod_r <= '0;
        if (j_r == 2'd3) i_r <= i_r + 1'b1;
        j_r <= j_r + 1'b1;
      end
      ST_PRJ_RD: ;
      ST_PRJ_MAC: begin
        if (k_r == 2'd3) prod_r <= 64'(a_val);
        else prod_r <= (64'(a_val) * 64'(mul_b)) >>> FRAC_BITS;
        if (k_r != 2'd0) acc_r <= sum;
        k_r <= k_r + 1'b1;
      end
      ST_PRJ_SAT: begin
        unique case (col_r)
          2'd0: cx_r <= sat_v[31:0];
          2'd1: cy_r <= sat_v[31:0];
          default: cw_r <= sat_v[31:0];
        endcase
        col_r <= (col_r == 2'd1) ? 2'd3 : col_r + 1'b1;
        acc_r <= '0; prod_r <= '0;
        front_r <= sat_v > W_MIN;
        sx_r <= '0; sy_r <= '0;
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_sel_r) ry_r <= rclamp;
          else rx_r <= rclamp;
          div_sel_r <= 1'b1;
        end
      end
      ST_SCALE: begin
        sx_r <= sat32(ext_x >>> 1);
        sy_r <= sat32(ext_y >>> 1);
      end
      ST_OUT: begin
        if (out_load) begin
          out_screen_x <= sx_r;
          out_screen_y <= sy_r;
          out_in_front <= front_r;
          out_on_screen <= !sx_r[31] && !sy_r[31] &&
                           (64'(sx_r) <= (64'(w_r) <<< FRAC_BITS)) &&
                           (64'(sy_r) <= (64'(h_r) <<< FRAC_BITS));
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* hdl/wsp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_checker
// Port-level checks of the world to screen projector.
// ----------------------------------------------------------------------------
`include "world_to_screen_projector_defines.svh"
module wsp_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_in_front,
  input wire logic out_on_screen,
  input wire logic signed [31:0] out_screen_x,
  input wire logic signed [31:0] out_screen_y
);
  // a stalled result keeps its screen coordinates
  `WSP_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall,
    $stable(out_screen_x) && $stable(out_screen_y))
  // a point behind the viewer lands at the origin and counts as on screen
  `WSP_ASSERT_IMPL(a_behind, clk, rst_n, out_valid && !out_in_front,
    out_screen_x == 32'sd0 && out_screen_y == 32'sd0 && out_on_screen)
  // a stalled result stays
  `WSP_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid)
endmodule

bind world_to_screen_projector wsp_checker u_wsp_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_valid), .out_stall(out_stall), .out_in_front(out_in_front),
  .out_on_screen(out_on_screen), .out_screen_x(out_screen_x),
  .out_screen_y(out_screen_y)
);
`default_nettype wire
